// ===== hw/rtl/owub_pkg.sv =====
// Shared types, codes and sizes for the one-wire-over-UART bit engine.
// No dependencies; imported by every module of the block.
package owub_pkg;

    localparam int STORE_BYTES   = 16;
    localparam int STORE_IDX_W   = $clog2(STORE_BYTES);
    localparam int READ_MAX_BITS = STORE_BYTES * 8;
    localparam int WRITE_MAX_BITS = 8;

    localparam logic [7:0] TX_RESET = 8'hF0;
    localparam logic [7:0] TX_ONE   = 8'hFF;
    localparam logic [7:0] TX_ZERO  = 8'h00;

    typedef enum logic [2:0] {
        OP_BUS_RESET   = 3'd0,
        OP_START_WRITE = 3'd1,
        OP_START_READ  = 3'd2,
        OP_TX_READY    = 3'd3,
        OP_RX_BYTE     = 3'd4,
        OP_READ_STORED = 3'd5
    } opcode_t;

    typedef enum logic [1:0] {
        MODE_IDLE  = 2'd0,
        MODE_WRITE = 2'd1,
        MODE_READ  = 2'd2
    } op_mode_t;

    typedef struct packed {
        logic [2:0] opcode;
        logic [7:0] write_value;
        logic [7:0] bit_count;
        logic [7:0] rx_data;
        logic [3:0] store_index;
    } in_word_t;

    typedef struct packed {
        logic       tx_valid;
        logic [7:0] tx_byte;
        logic       slow_baud;
        logic       done_res;
        logic [7:0] partial_bits;
        logic [7:0] stored_byte;
    } out_word_t;

endpackage

// ===== hw/rtl/owub_in_stage.sv =====
// Input register stage: captures one incoming word per cycle unless held by down_ready.
// Depends on owub_pkg.
module owub_in_stage (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              up_valid,
    output logic              up_ready,
    input  owub_pkg::in_word_t up_word,
    output logic              down_valid,    // valid toward core
    input  logic              down_ready,
    output owub_pkg::in_word_t down_word
);
    import owub_pkg::*;

    logic     vld_reg;
    logic     vld_next;
    in_word_t word_reg;
    logic     pass;

    assign pass     = vld_reg && down_ready;
    assign up_ready = !vld_reg || pass;
    assign vld_next = up_ready ? up_valid : vld_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (up_ready && up_valid)
        begin
            word_reg <= up_word;
        end
    end

    assign down_valid = vld_reg;
    assign down_word  = word_reg;

endmodule

// ===== hw/rtl/owub_core.sv =====
// Bus engine state, slot sequencing and the received-byte store.
// Depends on owub_pkg. State advances on fire; result is combinational.
module owub_core (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               fire,
    input  owub_pkg::in_word_t word,
    output owub_pkg::out_word_t result
);
    import owub_pkg::*;

    op_mode_t   mode_reg,  mode_next;
    logic       tx_en_reg, tx_en_next;
    logic       rx_en_reg, rx_en_next;
    logic [7:0] cnt_reg,   cnt_next;
    logic [7:0] limit_reg, limit_next;
    logic [7:0] shift_reg, shift_next;
    logic [7:0] asm_reg,   asm_next;
    logic       done_reg,  done_next;

    logic [7:0] store_mem [STORE_BYTES];
    logic                   store_we;
    logic [STORE_IDX_W-1:0] store_waddr;
    logic [4:0]             byte_idx;

    always_comb
    begin
        mode_next   = mode_reg;
        tx_en_next  = tx_en_reg;
        rx_en_next  = rx_en_reg;
        cnt_next    = cnt_reg;
        limit_next  = limit_reg;
        shift_next  = shift_reg;
        asm_next    = asm_reg;
        done_next   = done_reg;
        store_we    = 1'b0;
        byte_idx    = cnt_reg[7:3];
        store_waddr = byte_idx[STORE_IDX_W-1:0];
        result      = '0;

        case (word.opcode)
            OP_BUS_RESET:
            begin
                result.tx_valid  = 1'b1;
                result.tx_byte   = TX_RESET;
                result.slow_baud = 1'b1;
            end
            OP_START_WRITE:
            begin
                rx_en_next = 1'b0;
                mode_next  = MODE_WRITE;
                if (word.bit_count == 8'd0)
                    limit_next = 8'd1;
                else if (int'(word.bit_count) > WRITE_MAX_BITS)
                    limit_next = 8'(WRITE_MAX_BITS);
                else
                    limit_next = word.bit_count;
                cnt_next   = 8'd0;
                asm_next   = 8'd0;
                shift_next = word.write_value;
                tx_en_next = 1'b1;
            end
            OP_START_READ:
            begin
                asm_next  = 8'd0;
                cnt_next  = 8'd0;
                mode_next = MODE_READ;
                if (word.bit_count == 8'd0)
                    limit_next = 8'd1;
                else if (int'(word.bit_count) > READ_MAX_BITS)
                    limit_next = 8'(READ_MAX_BITS);
                else
                    limit_next = word.bit_count;
                done_next  = 1'b0;
                tx_en_next = 1'b1;
            end
            OP_TX_READY:
            begin
                if (tx_en_reg)
                begin
                    tx_en_next = 1'b0;
                    rx_en_next = 1'b0;
                    if (mode_reg == MODE_WRITE)
                    begin
                        if (cnt_reg < 8'd8)
                        begin
                            result.tx_valid = 1'b1;
                            result.tx_byte  = shift_reg[0] ? TX_ONE : TX_ZERO;
                            shift_next      = shift_reg >> 1;
                        end
                        cnt_next   = cnt_reg + 8'd1;
                        tx_en_next = 1'b1;
                        if (cnt_next >= limit_reg)
                        begin
                            tx_en_next = 1'b0;
                            mode_next  = MODE_IDLE;
                            cnt_next   = 8'd0;
                        end
                    end
                    else if (mode_reg == MODE_READ)
                    begin
                        rx_en_next      = 1'b1;
                        result.tx_valid = 1'b1;
                        result.tx_byte  = TX_ONE;
                    end
                end
            end
            OP_RX_BYTE:
            begin
                if (rx_en_reg)
                begin
                    tx_en_next = 1'b0;
                    rx_en_next = 1'b0;
                    if (word.rx_data == TX_ONE)
                        asm_next = asm_reg | (8'd1 << cnt_reg[2:0]);
                    if (cnt_reg[2:0] == 3'd7)
                    begin
                        store_we = int'(byte_idx) < STORE_BYTES;
                        asm_next = 8'd0;
                    end
                    cnt_next = cnt_reg + 8'd1;
                    if (cnt_next < limit_reg)
                        tx_en_next = 1'b1;
                    else
                        done_next = 1'b1;
                end
            end
            OP_READ_STORED:
            begin
                if (int'(word.store_index) < STORE_BYTES)
                    result.stored_byte =
                        store_mem[word.store_index[STORE_IDX_W-1:0]];
            end
            default:
            begin
            end
        endcase

        result.done_res     = done_next;
        result.partial_bits = asm_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= MODE_IDLE;
            tx_en_reg <= 1'b0;
            rx_en_reg <= 1'b0;
            cnt_reg   <= 8'd0;
            limit_reg <= 8'd0;
            shift_reg <= 8'd0;
            asm_reg   <= 8'd0;
            done_reg  <= 1'b0;
        end
        else if (fire)
        begin
            mode_reg  <= mode_next;
            tx_en_reg <= tx_en_next;
            rx_en_reg <= rx_en_next;
            cnt_reg   <= cnt_next;
            limit_reg <= limit_next;
            shift_reg <= shift_next;
            asm_reg   <= asm_next;
            done_reg  <= done_next;
        end
    end

    // Completed byte carries the newly sampled bit, taken before the clear.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < STORE_BYTES; i++)
            begin
                store_mem[i] <= 8'd0;
            end
        end
        else if (fire && store_we)
        begin
            store_mem[store_waddr] <= asm_reg |
                ((word.rx_data == TX_ONE) ? (8'd1 << cnt_reg[2:0]) : 8'd0);
        end
    end

endmodule

// ===== hw/rtl/owub_out_stage.sv =====
// Output register stage: holds one result word until the sink takes it.
// Depends on owub_pkg.
module owub_out_stage (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                up_valid,
    output logic                up_ready,
    input  owub_pkg::out_word_t up_word,
    output logic                down_valid,
    input  logic                down_ready,
    output owub_pkg::out_word_t down_word
);
    import owub_pkg::*;

    logic      vld_reg;
    logic      vld_next;
    out_word_t word_reg;

    assign up_ready = !vld_reg || down_ready;
    assign vld_next = up_ready ? up_valid : vld_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (up_ready && up_valid)
        begin
            word_reg <= up_word;
        end
    end

    assign down_valid = vld_reg;
    assign down_word  = word_reg;

endmodule

// ===== hw/rtl/one_wire_uart_bit_engine.sv =====
// One-wire bus master carried over a UART, one UART byte per bus slot. Every
// input word is an event (bus reset, start write, start read, tx ready, rx
// byte, read stored) and yields exactly one result word: the UART byte to
// send if any (0xF0 slow-baud reset pulse, 0xFF for a one or a read slot,
// 0x00 for a zero), the done flag, the partially assembled receive byte and,
// for read stored, one byte of the 16-byte receive store. A word enters an
// input register, the engine updates its state and forms the result
// combinationally, and the result sits in an output register until taken.
// The block takes one word every cycle as long as the result side keeps up;
// the result is offered by the output register once the word has left the
// input register. Reset clears all state including the store at once.
// Depends on owub_pkg, owub_in_stage, owub_core, owub_out_stage.
module one_wire_uart_bit_engine (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // write_value[7:0], bit_count[15:8],
                                   // rx_data[23:16], store_index[27:24], zero pad
    input  logic [2:0]  s_tuser,   // opcode[2:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // tx_byte[7:0], done_res[8],
                                   // partial_bits[16:9], stored_byte[24:17], zero pad
    output logic [1:0]  m_tuser    // tx_valid[0], slow_baud[1]
);
    import owub_pkg::*;

    in_word_t  in_word;
    in_word_t  core_word;
    logic      in_valid;
    out_word_t core_result;
    out_word_t out_word;
    logic      out_ready;
    logic      fire;

    // Unpack the incoming word.
    assign in_word.opcode      = s_tuser;
    assign in_word.write_value = s_tdata[7:0];
    assign in_word.bit_count   = s_tdata[15:8];
    assign in_word.rx_data     = s_tdata[23:16];
    assign in_word.store_index = s_tdata[27:24];

    owub_in_stage u_in (
        .clk        (clk),
        .rst_n      (rst_n),
        .up_valid   (s_tvalid),
        .up_ready   (s_tready),
        .up_word    (in_word),
        .down_valid (in_valid),
        .down_ready (out_ready),
        .down_word  (core_word)
    );

    // Engine state moves exactly when a word passes into the output register.
    assign fire = in_valid && out_ready;

    owub_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .fire   (fire),
        .word   (core_word),
        .result (core_result)
    );

    owub_out_stage u_out (
        .clk        (clk),
        .rst_n      (rst_n),
        .up_valid   (in_valid),
        .up_ready   (out_ready),
        .up_word    (core_result),
        .down_valid (m_tvalid),
        .down_ready (m_tready),
        .down_word  (out_word)
    );

    // Pack the result word.
    assign m_tdata = {7'd0, out_word.stored_byte, out_word.partial_bits,
                      out_word.done_res, out_word.tx_byte};
    assign m_tuser = {out_word.slow_baud, out_word.tx_valid};

endmodule
